[design/mru_key_value_cache_core_defines.svh]
// assertion macros used by the checker file
`ifndef MRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define MRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define MKVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define MKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mkvc_pkg.sv]
`default_nettype none

package mkvc_pkg;

    localparam int CFG_W  = 5;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int MODE_W = 2;

    localparam logic [CFG_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] GET_MISS  = 32'hFFFF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_GET      = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_REMOVE   = 2'd3
    } t_mode;

endpackage

`default_nettype wire

[design/mru_key_value_cache_core.sv]
// an accepted input word passes through the input register and the result register to its result word
// throughput: one word per cycle unless the output stalls; lookup, rank update and slot choice are combinational
// a full output register that is not taken stalls the input register, which, when full, stalls the input side
// reset (i_rst_n low, synchronous): valid map and occupancy cleared, capacity set to 16,
// pipeline emptied; key, data and rank storage are not reset
`default_nettype none

module mru_key_value_cache_core #(
    parameter int ENTRIES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: capacity
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [mkvc_pkg::CFG_W-1:0]    i_cfg_wr_data,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [63:0]                   i_s_axis_tdata,   // key[31:0], value[63:32]
    input  wire logic [mkvc_pkg::MODE_W-1:0]   i_s_axis_tuser,   // mode[1:0]
    // result stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [mkvc_pkg::DATA_W-1:0]        o_m_axis_tdata,   // read_value[31:0]
    output logic                               o_m_axis_tuser    // found[0]
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > mkvc_pkg::CFG_W) ? CNT_W : mkvc_pkg::CFG_W;
    localparam int KW    = mkvc_pkg::KEY_W;
    localparam int DW    = mkvc_pkg::DATA_W;

    // configuration
    logic [mkvc_pkg::CFG_W-1:0] r_capacity;

    // input register
    logic                r_in_valid;
    mkvc_pkg::t_mode     r_in_mode;
    logic [KW-1:0]       r_in_key;
    logic [DW-1:0]       r_in_value;

    // entry table
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [KW-1:0]       r_key  [ENTRIES];
    logic [KW-1:0]       n_key  [ENTRIES];
    logic [DW-1:0]       r_data [ENTRIES];
    logic [DW-1:0]       n_data [ENTRIES];
    logic [IW-1:0]       r_rank [ENTRIES];
    logic [IW-1:0]       n_rank [ENTRIES];
    logic [CNT_W-1:0]    r_occ, n_occ;

    // result register
    logic                r_out_valid;
    logic                r_out_found;
    logic [DW-1:0]       r_out_data;
    logic                n_out_found;
    logic [DW-1:0]       n_out_data;

    // lookup
    logic [ENTRIES-1:0]  hit_vec;
    logic                hit;
    logic [IW-1:0]       hit_idx;
    logic [IW-1:0]       hit_rank;
    logic [DW-1:0]       hit_data;
    logic                free_found;
    logic [IW-1:0]       free_idx;
    logic                victim_found;
    logic [IW-1:0]       victim_idx;
    logic [CMP_W-1:0]    cap_ext;
    logic [CMP_W-1:0]    eff_cap;
    logic                full;

    logic                advance;
    logic                do_proc;
    logic                in_accept;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign do_proc         = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_found;

    // parallel key compare; valid keys are unique so the hit vector has at most one bit set
    always_comb begin
        hit_rank = '0;
        hit_data = '0;
        hit_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == r_in_key);
            hit_rank   = hit_rank | (r_rank[i] & {IW{hit_vec[i]}});
            hit_data   = hit_data | (r_data[i] & {DW{hit_vec[i]}});
            if (hit_vec[i]) begin
                hit_idx = IW'(i);
            end
        end
        hit = |hit_vec;
    end

    // lowest free slot and the most recent entry
    always_comb begin
        free_found   = 1'b0;
        free_idx     = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
            if (r_valid[i] && (r_rank[i] == '0)) begin
                victim_found = 1'b1;
                victim_idx   = IW'(i);
            end
        end
    end

    // capacity clamped to 1..ENTRIES
    always_comb begin
        cap_ext = CMP_W'(r_capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        full = CMP_W'(r_occ) >= eff_cap;
    end

    // table update
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_data  = r_data;
        n_rank  = r_rank;
        n_occ   = r_occ;
        if (do_proc) begin
            case (r_in_mode)
                mkvc_pkg::MODE_INSERT: begin
                    if (hit) begin
                        n_data[hit_idx] = r_in_value;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                                n_rank[i] = r_rank[i] + 1'b1;
                            end
                        end
                        n_rank[hit_idx] = '0;
                    end else if (full) begin
                        // most recent entry gives up its slot, its rank stays 0
                        if (victim_found) begin
                            n_key[victim_idx]  = r_in_key;
                            n_data[victim_idx] = r_in_value;
                        end
                    end else if (free_found) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i]) begin
                                n_rank[i] = r_rank[i] + 1'b1;
                            end
                        end
                        n_valid[free_idx] = 1'b1;
                        n_key[free_idx]   = r_in_key;
                        n_data[free_idx]  = r_in_value;
                        n_rank[free_idx]  = '0;
                        n_occ             = r_occ + 1'b1;
                    end
                end
                mkvc_pkg::MODE_GET: begin
                    if (hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                                n_rank[i] = r_rank[i] + 1'b1;
                            end
                        end
                        n_rank[hit_idx] = '0;
                    end
                end
                mkvc_pkg::MODE_REMOVE: begin
                    if (hit) begin
                        n_valid[hit_idx] = 1'b0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (r_valid[i] && (r_rank[i] > hit_rank)) begin
                                n_rank[i] = r_rank[i] - 1'b1;
                            end
                        end
                        if (r_occ != '0) begin
                            n_occ = r_occ - 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result word
    always_comb begin
        n_out_found = hit;
        n_out_data  = '0;
        if (r_in_mode == mkvc_pkg::MODE_GET) begin
            n_out_data = hit ? hit_data : mkvc_pkg::GET_MISS;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= mkvc_pkg::CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_occ       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_capacity <= i_cfg_wr_data;
            end
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode  <= mkvc_pkg::t_mode'(i_s_axis_tuser);
            r_in_key   <= i_s_axis_tdata[KW-1:0];
            r_in_value <= i_s_axis_tdata[KW+DW-1:KW];
        end
        if (do_proc) begin
            r_out_found <= n_out_found;
            r_out_data  <= n_out_data;
        end
        r_key  <= n_key;
        r_data <= n_data;
        r_rank <= n_rank;
    end

endmodule

`default_nettype wire

[design/mkvc_checker.sv]
`default_nettype none

`include "mru_key_value_cache_core_defines.svh"

module mkvc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_axis_tvalid,
    input wire logic                          o_s_axis_tready,
    input wire logic                          o_m_axis_tvalid,
    input wire logic                          i_m_axis_tready,
    input wire logic [mkvc_pkg::DATA_W-1:0]   o_m_axis_tdata,
    input wire logic                          o_m_axis_tuser
);

    // a stalled result word holds
    `MKVC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "result word changed while stalled")

    // input side only backs up when both pipeline registers hold a word
    `MKVC_ASSERT_NOW(a_in_stall, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid && !i_m_axis_tready, "input stalled without output back-pressure")

    // a miss reads either zero or the get-miss marker
    `MKVC_ASSERT_NOW(a_miss_value, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, (o_m_axis_tdata == '0) || (o_m_axis_tdata == mkvc_pkg::GET_MISS), "miss with unexpected read value")

    // pipeline is empty right after reset
    `MKVC_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $rose(i_rst_n), !o_m_axis_tvalid && o_s_axis_tready, "pipeline not empty after reset")

endmodule

bind mru_key_value_cache_core mkvc_checker u_mkvc_checker (.*);

`default_nettype wire
